>>> sv/pbb_pkg.sv
// pbb_pkg: shared types, constants and saturation helper for the padded bounding box block
// used by pbb_axis_accum, pbb_axis_scale and padded_bounding_box_accumulator; no dependencies
`default_nettype none

package pbb_pkg;

  localparam int WORD_W     = 32;
  localparam int RADIUS_W   = 31;
  localparam int MARGIN_W   = 16;
  localparam int PROD_W     = WORD_W + MARGIN_W;
  localparam int MARGIN_FRAC = 13;
  localparam int HALF_W     = PROD_W + 1 - MARGIN_FRAC;
  localparam int SAT_W      = HALF_W + 2;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [RADIUS_W-1:0]      radius_t;
  typedef logic [MARGIN_W-1:0]      margin_t;
  typedef logic [PROD_W-1:0]        prod_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam margin_t  MARGIN_ONE   = 16'd4096;
  localparam logic [PROD_W:0] MARGIN_ROUND = (PROD_W+1)'(1) << (MARGIN_FRAC - 1);

  localparam cfg_idx_t REG_JOINT_RADIUS  = 2'd0;
  localparam cfg_idx_t REG_END_RADIUS    = 2'd1;
  localparam cfg_idx_t REG_MARGIN_FACTOR = 2'd2;

  // per-point accumulate control
  typedef struct packed {
    logic step;
    logic first;
    logic last;
  } accum_ctl_t;

  // stage loads of the result pipeline
  typedef struct packed {
    logic load_b;
    logic load_c;
  } scale_ctl_t;

  // clamp a wide signed value into the signed word range
  function automatic word_t sat_word(input logic [SAT_W-1:0] v);
    word_t r;
    if ((&v[SAT_W-1:WORD_W-1]) || (~|v[SAT_W-1:WORD_W-1])) begin
      r = v[WORD_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/padded_bounding_box_accumulator.sv
// padded_bounding_box_accumulator: top level, input register, box accumulate, result pipeline
// throughput: one point word per cycle; the input stalls only while a last point waits on a full result pipeline
// result path: a last point moves through the input register, stage b (final box), stage c and the output register
// reset: rst is synchronous; clears valids, box, radii to 0 and margin to 1.0
// depends on pbb_pkg, pbb_axis_accum, pbb_axis_scale
`default_nettype none

module padded_bounding_box_accumulator
  import pbb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  // configuration write port
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_index,
  input  wire radius_t  cfg_data,
  // point channel
  input  wire logic     point_valid,
  output logic          point_stall,
  input  wire word_t    pos_x,
  input  wire word_t    pos_y,
  input  wire word_t    pos_z,
  input  wire logic     is_end,
  input  wire logic     last_point,
  // box channel
  output logic          box_valid,
  input  wire logic     box_stall,
  output word_t         min_x,
  output word_t         min_y,
  output word_t         min_z,
  output word_t         max_x,
  output word_t         max_y,
  output word_t         max_z,
  output word_t         mid_x,
  output word_t         mid_y,
  output word_t         mid_z
);

  // configuration registers
  radius_t joint_radius;
  radius_t end_radius;
  margin_t margin_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_radius  <= '0;
      end_radius    <= '0;
      margin_factor <= MARGIN_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_JOINT_RADIUS:  joint_radius  <= cfg_data;
        REG_END_RADIUS:    end_radius    <= cfg_data;
        REG_MARGIN_FACTOR: margin_factor <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage a: input register
  logic  a_valid;
  logic  a_end;
  logic  a_last;
  word_t a_x;
  word_t a_y;
  word_t a_z;

  // pipeline valids behind the box
  logic b_valid;
  logic c_valid;
  logic set_started;

  // ready chain, output side first
  logic ready_o;
  logic ready_c;
  logic ready_b;
  logic a_adv;
  logic load_a;
  logic load_o;

  accum_ctl_t acc_ctl;
  scale_ctl_t scl_ctl;
  radius_t    radius;

  always_comb begin
    ready_o     = !box_valid || !box_stall;
    ready_c     = !c_valid || ready_o;
    ready_b     = !b_valid || ready_c;
    // only a last point needs room downstream; others just fold into the box
    a_adv       = a_valid && (!a_last || ready_b);
    point_stall = a_valid && !a_adv;
    load_a      = point_valid && !point_stall;
    load_o      = c_valid && ready_o;
    radius      = a_end ? end_radius : joint_radius;

    acc_ctl.step  = a_adv;
    acc_ctl.first = !set_started;
    acc_ctl.last  = a_last;

    scl_ctl.load_b = a_adv && a_last;
    scl_ctl.load_c = b_valid && ready_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      box_valid   <= 1'b0;
      set_started <= 1'b0;
    end else begin
      a_valid   <= load_a || (a_valid && !a_adv);
      b_valid   <= scl_ctl.load_b || (b_valid && !ready_c);
      c_valid   <= scl_ctl.load_c || (c_valid && !ready_o);
      box_valid <= load_o || (box_valid && box_stall);
      if (a_adv) begin
        set_started <= !a_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_x    <= pos_x;
      a_y    <= pos_y;
      a_z    <= pos_z;
      a_end  <= is_end;
      a_last <= last_point;
    end
  end

  // box accumulate, one slice per axis
  word_t box_lo_x, box_hi_x;
  word_t box_lo_y, box_hi_y;
  word_t box_lo_z, box_hi_z;

  pbb_axis_accum u_acc_x (
    .clk(clk), .rst(rst), .ctl(acc_ctl), .pos(a_x), .radius(radius),
    .box_lo(box_lo_x), .box_hi(box_hi_x)
  );

  pbb_axis_accum u_acc_y (
    .clk(clk), .rst(rst), .ctl(acc_ctl), .pos(a_y), .radius(radius),
    .box_lo(box_lo_y), .box_hi(box_hi_y)
  );

  pbb_axis_accum u_acc_z (
    .clk(clk), .rst(rst), .ctl(acc_ctl), .pos(a_z), .radius(radius),
    .box_lo(box_lo_z), .box_hi(box_hi_z)
  );

  // center and margin, two stages per axis
  word_t res_lo_x, res_hi_x, res_mid_x;
  word_t res_lo_y, res_hi_y, res_mid_y;
  word_t res_lo_z, res_hi_z, res_mid_z;

  pbb_axis_scale u_scl_x (
    .clk(clk), .ctl(scl_ctl), .lo(box_lo_x), .hi(box_hi_x), .margin(margin_factor),
    .res_lo(res_lo_x), .res_hi(res_hi_x), .res_mid(res_mid_x)
  );

  pbb_axis_scale u_scl_y (
    .clk(clk), .ctl(scl_ctl), .lo(box_lo_y), .hi(box_hi_y), .margin(margin_factor),
    .res_lo(res_lo_y), .res_hi(res_hi_y), .res_mid(res_mid_y)
  );

  pbb_axis_scale u_scl_z (
    .clk(clk), .ctl(scl_ctl), .lo(box_lo_z), .hi(box_hi_z), .margin(margin_factor),
    .res_lo(res_lo_z), .res_hi(res_hi_z), .res_mid(res_mid_z)
  );

  // output register, holds while the box word is stalled
  always_ff @(posedge clk) begin
    if (load_o) begin
      min_x <= res_lo_x;
      min_y <= res_lo_y;
      min_z <= res_lo_z;
      max_x <= res_hi_x;
      max_y <= res_hi_y;
      max_z <= res_hi_z;
      mid_x <= res_mid_x;
      mid_y <= res_mid_y;
      mid_z <= res_mid_z;
    end
  end

`ifndef NO_ASSERTIONS
  // only a last point waiting on a full result pipeline can hold the input
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    point_stall |-> (a_valid && a_last && b_valid && c_valid && box_valid && box_stall))
    else $error("point stall without a blocked last point");

  // a finished set leaves the box empty for the next one
  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (a_adv && a_last) |=> (!set_started && b_valid))
    else $error("last point did not close the set");

  // a blocked scale stage keeps its word
  a_c_hold: assert property (@(posedge clk) disable iff (rst)
    (c_valid && !ready_o) |=> c_valid)
    else $error("scale stage word lost under stall");

  // a result only enters the output register from the scale stage
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    (!$past(box_valid) && box_valid) |-> $past(c_valid))
    else $error("box word without a source");
`endif

endmodule

`default_nettype wire

>>> sv/pbb_axis_accum.sv
// pbb_axis_accum: one axis of the running box, padded min/max with saturation
// depends on pbb_pkg
`default_nettype none

module pbb_axis_accum
  import pbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire accum_ctl_t ctl,
  input  wire word_t      pos,
  input  wire radius_t    radius,
  output word_t           box_lo,
  output word_t           box_hi
);

  word_t low_corner;
  word_t high_corner;

  logic [WORD_W:0] diff;
  logic [WORD_W:0] sum;
  word_t           pad_lo;
  word_t           pad_hi;

  always_comb begin
    diff   = {pos[WORD_W-1], pos} - {2'b00, radius};
    sum    = {pos[WORD_W-1], pos} + {2'b00, radius};
    pad_lo = sat_word({{(SAT_W-WORD_W-1){diff[WORD_W]}}, diff});
    pad_hi = sat_word({{(SAT_W-WORD_W-1){sum[WORD_W]}}, sum});
    box_lo = (ctl.first || (pad_lo < low_corner))  ? pad_lo : low_corner;
    box_hi = (ctl.first || (pad_hi > high_corner)) ? pad_hi : high_corner;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_corner  <= '0;
      high_corner <= '0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        low_corner  <= '0;
        high_corner <= '0;
      end else begin
        low_corner  <= box_lo;
        high_corner <= box_hi;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/pbb_axis_scale.sv
// pbb_axis_scale: one axis of the result pipeline, center and margin rescale
// depends on pbb_pkg
`default_nettype none

module pbb_axis_scale
  import pbb_pkg::*;
(
  input  wire logic       clk,
  input  wire scale_ctl_t ctl,
  input  wire word_t      lo,
  input  wire word_t      hi,
  input  wire margin_t    margin,
  output word_t           res_lo,
  output word_t           res_hi,
  output word_t           res_mid
);

  // stage b: final box
  word_t b_lo;
  word_t b_hi;

  // stage c: center and scaled extent
  word_t c_lo;
  word_t c_hi;
  word_t c_mid;
  prod_t c_prod;
  logic  c_one;

  logic [WORD_W:0]    mid_sum;
  logic [WORD_W-1:0]  ext;
  prod_t              prod;
  logic [PROD_W:0]    rounded;
  logic [HALF_W-1:0]  half;
  logic [SAT_W-1:0]   mid_w;
  logic [SAT_W-1:0]   new_lo;
  logic [SAT_W-1:0]   new_hi;

  always_comb begin
    mid_sum = {b_lo[WORD_W-1], b_lo} + {b_hi[WORD_W-1], b_hi};
    // hi never below lo, so the word difference is the exact extent
    ext     = b_hi - b_lo;
    prod    = PROD_W'(ext) * PROD_W'(margin);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      b_lo <= lo;
      b_hi <= hi;
    end
    if (ctl.load_c) begin
      c_lo   <= b_lo;
      c_hi   <= b_hi;
      c_mid  <= mid_sum[WORD_W:1];
      c_prod <= prod;
      c_one  <= (margin == MARGIN_ONE);
    end
  end

  always_comb begin
    rounded = {1'b0, c_prod} + MARGIN_ROUND;
    half    = rounded[PROD_W:MARGIN_FRAC];
    mid_w   = {{(SAT_W-WORD_W){c_mid[WORD_W-1]}}, c_mid};
    new_lo  = mid_w - {2'b00, half};
    new_hi  = mid_w + {2'b00, half};
    res_mid = c_mid;
    res_lo  = c_one ? c_lo : sat_word(new_lo);
    res_hi  = c_one ? c_hi : sat_word(new_hi);
  end

endmodule

`default_nettype wire
